FILE: design/tes_pkg.sv
// ----------------------------------------------------------------------------
// tes_pkg
// shared types and constants of the text encoding sniffer
// ----------------------------------------------------------------------------
package tes_pkg;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_LONG_LENGTH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LONG_MARGIN = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SWAP_LIMIT  = 2'd2;

  // register reset values
  localparam int unsigned LONG_LENGTH_RST = 200;
  localparam logic [7:0]  LONG_MARGIN_RST = 8'd15;
  localparam logic [7:0]  SWAP_LIMIT_RST  = 8'd25;

  // result codes
  localparam logic [2:0] ENC_UNKNOWN  = 3'd0;
  localparam logic [2:0] ENC_UTF8     = 3'd1;
  localparam logic [2:0] ENC_UTF16BE  = 3'd2;
  localparam logic [2:0] ENC_UTF16LE  = 3'd3;
  localparam logic [2:0] ENC_UTF32BE  = 3'd4;
  localparam logic [2:0] ENC_UTF32LE  = 3'd5;

  // byte values of interest
  localparam logic [7:0] BYTE_ZERO     = 8'h00;
  localparam logic [7:0] BYTE_SPACE    = 8'h20;
  localparam logic [7:0] BYTE_DEL      = 8'h7F;
  localparam logic [7:0] BYTE_CONT_LO  = 8'h80;
  localparam logic [7:0] BYTE_CONT_HI  = 8'hBF;
  localparam logic [7:0] BYTE_LEAD_LO  = 8'hC0;
  localparam logic [7:0] BYTE_LEAD_HI  = 8'hF7;
  localparam logic [7:0] BYTE_BOM_UTF8 = 8'hEF;
  localparam logic [7:0] BYTE_BOM_FE   = 8'hFE;
  localparam logic [7:0] BYTE_BOM_FF   = 8'hFF;

  // mark bonuses
  localparam int BONUS_FULL = 100;
  localparam int BONUS_HALF = 50;

  localparam int unsigned QUEUE_DEPTH = 2;

  // work item passed from front end to back end
  typedef struct packed {
    logic       first;      // first byte of a buffer: mark check
    logic       short_buf;  // buffer shorter than four bytes
    logic       score_a;    // score the pending byte
    logic [1:0] pos_a;      // low bits of its position
    logic [7:0] prev_a;     // byte before the pending byte
    logic [7:0] cur_a;      // pending byte
    logic [7:0] byte_in;    // byte just accepted
    logic       last;       // buffer ends here
    logic       score_b;    // also score the byte just accepted
    logic [1:0] pos_b;
    logic       len_long;   // length above long_length
  } entry_t;

  typedef enum logic [1:0] {
    PH_MAIN,
    PH_TAIL,
    PH_DECIDE
  } phase_t;

endpackage

FILE: design/tes_if.sv
// ----------------------------------------------------------------------------
// tes_in_if / tes_out_if
// valid/ready channels of the text encoding sniffer
// ----------------------------------------------------------------------------
interface tes_in_if #(
  parameter int LENGTH_WIDTH = 16
) ();
  logic                    valid;
  logic                    ready;
  logic [7:0]              byte_value;
  logic [LENGTH_WIDTH-1:0] total_length;
  logic                    last_byte;

  modport source (output valid, byte_value, total_length, last_byte, input ready);
  modport sink   (input valid, byte_value, total_length, last_byte, output ready);
endinterface

interface tes_out_if ();
  logic       valid;
  logic       ready;
  logic [2:0] detected_encoding;

  modport source (output valid, detected_encoding, input ready);
  modport sink   (input valid, detected_encoding, output ready);
endinterface

FILE: design/tes_front.sv
// ----------------------------------------------------------------------------
// tes_front
// accepts bytes, tracks position and scan window, builds queue entries
// ----------------------------------------------------------------------------
module tes_front #(
  parameter int LENGTH_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  tes_in_if.sink                  in_ch,
  input  logic [LENGTH_WIDTH-1:0] long_length,
  input  logic                    q_full,
  output logic                    push,
  output tes_pkg::entry_t         push_entry
);

  logic [LENGTH_WIDTH-1:0] pos_r, pos_nxt;
  logic [7:0]              prev_r, prev_nxt;
  logic [7:0]              pend_r, pend_nxt;
  logic                    scan_r, scan_nxt;

  logic [LENGTH_WIDTH-1:0] len;
  logic [LENGTH_WIDTH-1:0] limit;
  logic [LENGTH_WIDTH-1:0] pos_m1;
  logic                    len_long;
  logic                    first;
  logic                    live;
  logic                    short_buf;
  logic                    has_mark;
  logic [7:0]              b;

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  assign b         = in_ch.byte_value;
  assign len       = in_ch.total_length;
  assign len_long  = len > long_length;
  assign limit     = len_long ? (len >> 1) : len;
  assign pos_m1    = pos_r - LENGTH_WIDTH'(1);
  assign first     = pos_r == '0;
  assign live      = pos_r != '1;
  assign short_buf = len < LENGTH_WIDTH'(4);
  assign has_mark  = (b == tes_pkg::BYTE_ZERO && !short_buf) ||
                     b == tes_pkg::BYTE_BOM_UTF8 || b == tes_pkg::BYTE_BOM_FE ||
                     b == tes_pkg::BYTE_BOM_FF;

  always_comb begin
    push_entry           = '0;
    push_entry.first     = first;
    push_entry.short_buf = short_buf;
    push_entry.score_a   = !first && live && pos_r >= LENGTH_WIDTH'(2) && scan_r &&
                           pos_m1 < limit;
    push_entry.pos_a     = pos_m1[1:0];
    push_entry.prev_a    = prev_r;
    push_entry.cur_a     = pend_r;
    push_entry.byte_in   = b;
    push_entry.last      = in_ch.last_byte;
    push_entry.score_b   = in_ch.last_byte && live && !first && scan_r && pos_r < limit;
    push_entry.pos_b     = pos_r[1:0];
    push_entry.len_long  = len_long;
  end

  always_comb begin
    pos_nxt  = pos_r;
    prev_nxt = prev_r;
    pend_nxt = pend_r;
    scan_nxt = scan_r;
    if (push) begin
      if (in_ch.last_byte) begin
        pos_nxt  = '0;
        prev_nxt = '0;
        pend_nxt = '0;
        scan_nxt = 1'b0;
      end else begin
        prev_nxt = pend_r;
        pend_nxt = b;
        if (live) begin
          pos_nxt = pos_r + LENGTH_WIDTH'(1);
        end
        if (first) begin
          scan_nxt = !has_mark;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      prev_r <= '0;
      pend_r <= '0;
      scan_r <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      prev_r <= prev_nxt;
      pend_r <= pend_nxt;
      scan_r <= scan_nxt;
    end
  end

endmodule

FILE: design/tes_queue.sv
// ----------------------------------------------------------------------------
// tes_queue
// two-entry queue between front end and back end
// ----------------------------------------------------------------------------
module tes_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  tes_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output tes_pkg::entry_t head,
  output logic            empty
);

  localparam int PTR_W = $clog2(tes_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(tes_pkg::QUEUE_DEPTH + 1);

  tes_pkg::entry_t store_r [tes_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full  = count_r == CNT_W'(tes_pkg::QUEUE_DEPTH);
  assign empty = count_r == '0;
  assign head  = store_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(tes_pkg::QUEUE_DEPTH - 1)) ? '0 :
                   wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(tes_pkg::QUEUE_DEPTH - 1)) ? '0 :
                   rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

FILE: design/tes_back.sv
// ----------------------------------------------------------------------------
// tes_back
// scoring unit, weight registers, decision and result register
// ----------------------------------------------------------------------------
module tes_back #(
  parameter int WEIGHT_WIDTH = 24
) (
  input  logic            clk,
  input  logic            rst_n,
  input  tes_pkg::entry_t head,
  input  logic            empty,
  output logic            pop,
  input  logic [7:0]      long_margin,
  input  logic [7:0]      swap_limit,
  tes_out_if.source       out_ch
);

  localparam int W = WEIGHT_WIDTH;

  typedef logic signed [W-1:0] weight_t;
  typedef logic signed [W:0]   wide_t;

  function automatic weight_t sat_add(input weight_t w, input logic signed [3:0] d);
    wide_t s;
    s = wide_t'(w) + wide_t'(d);
    if (s[W] != s[W-1]) begin
      sat_add = s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      sat_add = s[W-1:0];
    end
  endfunction

  function automatic logic printable(input logic [7:0] c);
    printable = c > tes_pkg::BYTE_SPACE && c < tes_pkg::BYTE_DEL;
  endfunction

  tes_pkg::phase_t phase_r, phase_nxt;
  weight_t w8_r, w16_r, w32_r, swap_r;
  weight_t w8_nxt, w16_nxt, w32_nxt, swap_nxt;
  logic    big_r, big_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [2:0] out_enc_r, out_enc_nxt;

  logic has_item, out_free;
  logic apply_first, apply_score, sel_tail, load_out;

  // scoring unit inputs
  logic [1:0] s_pos;
  logic [7:0] s_prev, s_cur, s_next;
  logic signed [3:0] d_swap, d8, d16, d32;
  weight_t sc_swap, sc_w8, sc_w16, sc_w32;
  logic    sc_big;
  wide_t   swap_ext, lim_ext;
  logic    cur_zero, is_cont, is_space, space_edge;

  // mark check
  weight_t fi_w8, fi_w16, fi_w32;

  // decision
  wide_t   m_ext, d8_16, d8_32, d16_8, d16_32, d32_8, d32_16;
  logic [2:0] enc;

  assign has_item = !empty;
  assign out_free = !out_valid_r || out_ch.ready;

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      tes_pkg::PH_MAIN: begin
        if (has_item && head.last) begin
          phase_nxt = head.score_b ? tes_pkg::PH_TAIL : tes_pkg::PH_DECIDE;
        end
      end
      tes_pkg::PH_TAIL: begin
        phase_nxt = tes_pkg::PH_DECIDE;
      end
      tes_pkg::PH_DECIDE: begin
        if (out_free) begin
          phase_nxt = tes_pkg::PH_MAIN;
        end
      end
      default: begin
        phase_nxt = tes_pkg::PH_MAIN;
      end
    endcase
  end

  // phase outputs
  always_comb begin
    apply_first = 1'b0;
    apply_score = 1'b0;
    sel_tail    = 1'b0;
    load_out    = 1'b0;
    pop         = 1'b0;
    case (phase_r)
      tes_pkg::PH_MAIN: begin
        apply_first = has_item && head.first;
        apply_score = has_item && head.score_a;
        pop         = has_item && !head.last;
      end
      tes_pkg::PH_TAIL: begin
        apply_score = 1'b1;
        sel_tail    = 1'b1;
      end
      tes_pkg::PH_DECIDE: begin
        load_out = out_free;
        pop      = out_free;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  // scoring unit, shared by the pending byte and the final byte
  always_comb begin
    s_pos  = sel_tail ? head.pos_b : head.pos_a;
    s_prev = sel_tail ? head.cur_a : head.prev_a;
    s_cur  = sel_tail ? head.byte_in : head.cur_a;
    s_next = sel_tail ? tes_pkg::BYTE_ZERO : head.byte_in;

    cur_zero   = s_cur == tes_pkg::BYTE_ZERO;
    is_cont    = s_cur >= tes_pkg::BYTE_CONT_LO && s_cur <= tes_pkg::BYTE_CONT_HI;
    is_space   = s_cur == tes_pkg::BYTE_SPACE;
    space_edge = s_prev == tes_pkg::BYTE_ZERO || s_next == tes_pkg::BYTE_ZERO;

    d_swap = '0;
    if (cur_zero) begin
      if (!s_pos[0]) begin
        if (s_pos[1] == 1'b0 || w16_r > w32_r) begin
          d_swap = 4'sd1;
        end
      end else begin
        d_swap = -4'sd1;
      end
    end
    sc_swap  = sat_add(swap_r, d_swap);
    swap_ext = wide_t'(sc_swap);
    lim_ext  = $signed({{(W+1-8){1'b0}}, swap_limit});
    sc_big   = big_r;
    if (swap_ext > lim_ext) begin
      sc_big = 1'b0;
    end else if (swap_ext < -lim_ext) begin
      sc_big = 1'b1;
    end

    d8  = '0;
    d16 = '0;
    d32 = '0;
    if (cur_zero) begin
      d8 = -4'sd1;
      if (s_next == tes_pkg::BYTE_ZERO) begin
        d32 = 4'sd1;
      end else begin
        d16 = 4'sd1;
      end
    end else if (is_cont) begin
      d8 = (s_prev >= tes_pkg::BYTE_LEAD_LO && s_prev <= tes_pkg::BYTE_LEAD_HI) ?
           4'sd2 : 4'sd1;
    end else if (is_space) begin
      if (space_edge) begin
        d16 = 4'sd1;
        d32 = 4'sd1;
      end else begin
        d8 = 4'sd2;
      end
    end else if (printable(s_cur) && printable(s_prev) && printable(s_next)) begin
      d8 = 4'sd5;
    end
    sc_w8  = sat_add(w8_r, d8);
    sc_w16 = sat_add(w16_r, d16);
    sc_w32 = sat_add(w32_r, d32);
  end

  // byte-order mark check on the first byte; other weights are zero, but utf-32 is -1 in a short buffer
  always_comb begin
    fi_w8  = '0;
    fi_w16 = '0;
    fi_w32 = head.short_buf ? '1 : '0;
    if (head.byte_in == tes_pkg::BYTE_ZERO && !head.short_buf) begin
      fi_w32 = weight_t'(tes_pkg::BONUS_FULL);
    end else if (head.byte_in == tes_pkg::BYTE_BOM_UTF8) begin
      fi_w8 = weight_t'(tes_pkg::BONUS_FULL);
    end else if (head.byte_in == tes_pkg::BYTE_BOM_FE) begin
      fi_w16 = weight_t'(tes_pkg::BONUS_FULL);
    end else if (head.byte_in == tes_pkg::BYTE_BOM_FF) begin
      fi_w16 = weight_t'(tes_pkg::BONUS_HALF);
      if (!head.short_buf) begin
        fi_w32 = weight_t'(tes_pkg::BONUS_HALF);
      end
    end
  end

  // margin decision
  always_comb begin
    m_ext  = head.len_long ? $signed({{(W+1-8){1'b0}}, long_margin}) : '0;
    d8_16  = wide_t'(w8_r) - wide_t'(w16_r);
    d8_32  = wide_t'(w8_r) - wide_t'(w32_r);
    d16_8  = wide_t'(w16_r) - wide_t'(w8_r);
    d16_32 = wide_t'(w16_r) - wide_t'(w32_r);
    d32_8  = wide_t'(w32_r) - wide_t'(w8_r);
    d32_16 = wide_t'(w32_r) - wide_t'(w16_r);
    if (d8_16 > m_ext && d8_32 > m_ext) begin
      enc = tes_pkg::ENC_UTF8;
    end else if (d16_8 > m_ext && d16_32 > m_ext) begin
      enc = big_r ? tes_pkg::ENC_UTF16BE : tes_pkg::ENC_UTF16LE;
    end else if (d32_8 > m_ext && d32_16 > m_ext) begin
      enc = big_r ? tes_pkg::ENC_UTF32BE : tes_pkg::ENC_UTF32LE;
    end else begin
      enc = tes_pkg::ENC_UNKNOWN;
    end
  end

  // register updates
  always_comb begin
    w8_nxt   = w8_r;
    w16_nxt  = w16_r;
    w32_nxt  = w32_r;
    swap_nxt = swap_r;
    big_nxt  = big_r;
    if (load_out) begin
      w8_nxt   = '0;
      w16_nxt  = '0;
      w32_nxt  = '0;
      swap_nxt = '0;
      big_nxt  = 1'b0;
    end else if (apply_first) begin
      w8_nxt  = fi_w8;
      w16_nxt = fi_w16;
      w32_nxt = fi_w32;
      big_nxt = head.byte_in != tes_pkg::BYTE_BOM_FF;
    end else if (apply_score) begin
      w8_nxt   = sc_w8;
      w16_nxt  = sc_w16;
      w32_nxt  = sc_w32;
      swap_nxt = sc_swap;
      big_nxt  = sc_big;
    end

    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_enc_nxt   = out_enc_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_enc_nxt   = enc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= tes_pkg::PH_MAIN;
      w8_r        <= '0;
      w16_r       <= '0;
      w32_r       <= '0;
      swap_r      <= '0;
      big_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      w8_r        <= w8_nxt;
      w16_r       <= w16_nxt;
      w32_r       <= w32_nxt;
      swap_r      <= swap_nxt;
      big_r       <= big_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_enc_r <= out_enc_nxt;
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.detected_encoding = out_enc_r;

endmodule

FILE: design/text_encoding_sniffer_core.sv
// ----------------------------------------------------------------------------
// text_encoding_sniffer_core
// guesses the encoding of a byte stream buffer: utf-8, utf-16 or utf-32
// ----------------------------------------------------------------------------
// Bytes of one buffer come in one per transaction, the buffer length on each,
// the final byte flagged by last_byte; that transaction yields exactly one
// result transaction with the encoding code (unknown, utf-8, utf-16 be/le,
// utf-32 be/le), no other byte yields anything. Throughput is one byte per
// cycle while a buffer streams and the queue is not full; the final byte of a
// buffer holds the back-end scoring unit while the pending byte is scored,
// then for an extra scoring pass when it is itself scored, then for the margin
// decision, which waits until the result register is free. A two-entry queue
// lets the front end take one more byte while a result waits on the output
// side. The three configuration registers should only be written between
// buffers.
// ----------------------------------------------------------------------------
module text_encoding_sniffer_core #(
  parameter int LENGTH_WIDTH = 16,
  parameter int WEIGHT_WIDTH = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  tes_in_if.sink                              in_ch,
  tes_out_if.source                           out_ch,
  input  logic                                cfg_we,
  input  logic [tes_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [LENGTH_WIDTH-1:0]             cfg_wdata
);

  // configuration registers
  logic [LENGTH_WIDTH-1:0] long_length_r, long_length_nxt;
  logic [7:0]              long_margin_r, long_margin_nxt;
  logic [7:0]              swap_limit_r, swap_limit_nxt;

  // queue between front end and back end
  logic            q_push;
  tes_pkg::entry_t q_push_entry;
  logic            q_full;
  logic            q_pop;
  tes_pkg::entry_t q_head;
  logic            q_empty;

  // register writes; an index outside the list is dropped
  always_comb begin
    long_length_nxt = long_length_r;
    long_margin_nxt = long_margin_r;
    swap_limit_nxt  = swap_limit_r;
    if (cfg_we) begin
      case (cfg_index)
        tes_pkg::CFG_LONG_LENGTH: long_length_nxt = cfg_wdata;
        tes_pkg::CFG_LONG_MARGIN: long_margin_nxt = cfg_wdata[7:0];
        tes_pkg::CFG_SWAP_LIMIT:  swap_limit_nxt  = cfg_wdata[7:0];
        default: begin
          long_length_nxt = long_length_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_length_r <= LENGTH_WIDTH'(tes_pkg::LONG_LENGTH_RST);
      long_margin_r <= tes_pkg::LONG_MARGIN_RST;
      swap_limit_r  <= tes_pkg::SWAP_LIMIT_RST;
    end else begin
      long_length_r <= long_length_nxt;
      long_margin_r <= long_margin_nxt;
      swap_limit_r  <= swap_limit_nxt;
    end
  end

  // front end: position, scan window and mark bookkeeping per transaction
  tes_front #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .long_length (long_length_r),
    .q_full      (q_full),
    .push        (q_push),
    .push_entry  (q_push_entry)
  );

  tes_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head),
    .empty      (q_empty)
  );

  // back end: weights, swap score, decision and result register
  tes_back #(
    .WEIGHT_WIDTH (WEIGHT_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (q_head),
    .empty       (q_empty),
    .pop         (q_pop),
    .long_margin (long_margin_r),
    .swap_limit  (swap_limit_r),
    .out_ch      (out_ch)
  );

  // a final byte always lands in the queue
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.last_byte) |=> !q_empty)
    else $error("final byte not queued");

  // a result only appears when the final entry of a buffer leaves the queue
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(q_pop && q_head.last))
    else $error("result without a finished buffer");

  // result code always in the defined range
  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.detected_encoding <= tes_pkg::ENC_UTF32LE))
    else $error("undefined encoding code");

endmodule
